FILE: design/elg_pkg.sv
// Shared constants for the ElGamal decryption block.
// No dependencies; imported by elgamal_decrypt.
package elg_pkg;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_MODULUS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_EXPONENT = 2'd1;

    localparam int MODULUS_RESET  = 257;
    localparam int EXPONENT_RESET = 1;

endpackage

FILE: design/elgamal_decrypt.sv
// ElGamal decryption: plain = (a^x mod p)^-1 * b mod p, bit-serial datapath.
// Depends on elg_pkg for register indexes and reset values.
//
// Usage: pulse start while busy is low; the result appears on plain_value with
// done high for one cycle and cannot be stalled. A transaction reduces both
// operands, runs a check and a square-and-multiply step for each bit of the
// exponent up to its highest set bit, a check and a restoring division for
// each Euclid step, a fix-up of the inverse and then the final product. All
// arithmetic runs through bit-serial shift-and-add or shift-and-subtract units
// that consume one bit per cycle. A modulus below two gives 0 in the cycle after start.
// The user must write configuration only while busy is low; the block does
// not enforce this. cfg_ready is always high.
module elgamal_decrypt
    import elg_pkg::*;
#(
    parameter int WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [WIDTH-1:0]      cipher_first,
    input  logic [WIDTH-1:0]      cipher_second,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [WIDTH-1:0]      cfg_data,
    output logic                  done,
    output logic [WIDTH-1:0]      plain_value
);

    localparam int SW    = WIDTH + 2;
    localparam int CNT_W = $clog2(WIDTH);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RED     = 3'd1;
    localparam logic [2:0] S_POW_CHK = 3'd2;
    localparam logic [2:0] S_POW     = 3'd3;
    localparam logic [2:0] S_EUC_CHK = 3'd4;
    localparam logic [2:0] S_DIV     = 3'd5;
    localparam logic [2:0] S_FIX     = 3'd6;
    localparam logic [2:0] S_MUL     = 3'd7;

    // One step of MSB-first interleaved modular multiplication.
    function automatic logic [WIDTH-1:0] mod_step(
        input logic [WIDTH-1:0] acc,
        input logic             bit_in,
        input logic [WIDTH-1:0] x,
        input logic [WIDTH-1:0] m
    );
        logic [WIDTH+1:0] t;
        logic [WIDTH+1:0] m1;
        logic [WIDTH+1:0] m2;
        begin
            m1 = {2'b00, m};
            m2 = {1'b0, m, 1'b0};
            t  = {1'b0, acc, 1'b0} + (bit_in ? {2'b00, x} : '0);
            if (t >= m2)
            begin
                t = t - m2;
            end
            else if (t >= m1)
            begin
                t = t - m1;
            end
            mod_step = t[WIDTH-1:0];
        end
    endfunction

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [WIDTH-1:0] modulus_reg, exponent_reg;

    logic [WIDTH-1:0] out_reg, out_next;
    logic [WIDTH-1:0] sh_reg, sh_next;
    logic [WIDTH-1:0] sh2_reg, sh2_next;
    logic [WIDTH-1:0] pa_reg, pa_next;
    logic [WIDTH-1:0] pb_reg, pb_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] sq_reg, sq_next;
    logic [WIDTH-1:0] bm_reg, bm_next;
    logic [WIDTH-1:0] expo_reg, expo_next;
    logic [WIDTH-1:0] num_reg, num_next;
    logic [WIDTH-1:0] den_reg, den_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic signed [SW-1:0] prev_reg, prev_next;
    logic signed [SW-1:0] cur_reg, cur_next;
    logic signed [SW-1:0] t_reg, t_next;

    logic             msb;
    logic [WIDTH:0]   rem_shift;
    logic             ge;
    logic signed [SW-1:0] p_s;
    logic signed [SW-1:0] fix_v;

    assign busy        = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign done        = done_reg;
    assign plain_value = out_reg;

    assign msb       = sh_reg[WIDTH-1];
    assign rem_shift = {rem_reg, msb};
    assign ge        = (rem_shift >= {1'b0, den_reg});
    assign p_s       = $signed({2'b00, modulus_reg});

    always_comb
    begin
        fix_v = (prev_reg < 0) ? prev_reg + p_s : prev_reg;
        if (fix_v < 0)
        begin
            fix_v = '0;
        end
        if (fix_v >= p_s)
        begin
            fix_v = fix_v - p_s;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg - 1'b1;
        done_next  = 1'b0;
        out_next   = out_reg;
        sh_next    = {sh_reg[WIDTH-2:0], 1'b0};
        sh2_next   = {sh2_reg[WIDTH-2:0], 1'b0};
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        bm_next    = bm_reg;
        expo_next  = expo_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        t_next     = t_reg;

        case (state_reg)
            S_IDLE:
            begin
                cnt_next = cnt_reg;
                if (start)
                begin
                    if (modulus_reg < WIDTH'(2))
                    begin
                        out_next  = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        sh_next    = cipher_first;
                        sh2_next   = cipher_second;
                        pa_next    = '0;
                        pb_next    = '0;
                        expo_next  = exponent_reg;
                        cnt_next   = CNT_W'(WIDTH - 1);
                        state_next = S_RED;
                    end
                end
            end
            S_RED:
            begin
                pa_next = mod_step(pa_reg, msb, WIDTH'(1), modulus_reg);
                pb_next = mod_step(pb_reg, sh2_reg[WIDTH-1], WIDTH'(1), modulus_reg);
                if (cnt_reg == '0)
                begin
                    sq_next    = pa_next;
                    bm_next    = pb_next;
                    acc_next   = WIDTH'(1);
                    state_next = S_POW_CHK;
                end
            end
            S_POW_CHK:
            begin
                if (expo_reg == '0)
                begin
                    num_next   = acc_reg;
                    den_next   = modulus_reg;
                    prev_next  = SW'(1);
                    cur_next   = '0;
                    state_next = S_EUC_CHK;
                end
                else
                begin
                    sh_next    = sq_reg;
                    pa_next    = '0;
                    pb_next    = '0;
                    cnt_next   = CNT_W'(WIDTH - 1);
                    state_next = S_POW;
                end
            end
            S_POW:
            begin
                // acc * sq and sq * sq share the multiplier bits of sq
                pa_next = mod_step(pa_reg, msb, acc_reg, modulus_reg);
                pb_next = mod_step(pb_reg, msb, sq_reg, modulus_reg);
                if (cnt_reg == '0)
                begin
                    if (expo_reg[0])
                    begin
                        acc_next = pa_next;
                    end
                    sq_next    = pb_next;
                    expo_next  = {1'b0, expo_reg[WIDTH-1:1]};
                    state_next = S_POW_CHK;
                end
            end
            S_EUC_CHK:
            begin
                if (den_reg == '0)
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    sh_next    = num_reg;
                    rem_next   = '0;
                    t_next     = '0;
                    cnt_next   = CNT_W'(WIDTH - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring division; accumulate quotient * cur alongside
                rem_next = ge ? WIDTH'(rem_shift - {1'b0, den_reg}) : rem_shift[WIDTH-1:0];
                t_next   = (t_reg <<< 1) + (ge ? cur_reg : SW'(0));
                if (cnt_reg == '0)
                begin
                    num_next   = den_reg;
                    den_next   = rem_next;
                    prev_next  = cur_reg;
                    cur_next   = prev_reg - t_next;
                    state_next = S_EUC_CHK;
                end
            end
            S_FIX:
            begin
                sh_next    = fix_v[WIDTH-1:0];
                pa_next    = '0;
                cnt_next   = CNT_W'(WIDTH - 1);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                pa_next = mod_step(pa_reg, msb, bm_reg, modulus_reg);
                if (cnt_reg == '0)
                begin
                    out_next   = pa_next;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            done_reg     <= 1'b0;
            modulus_reg  <= WIDTH'(MODULUS_RESET);
            exponent_reg <= WIDTH'(EXPONENT_RESET);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MODULUS)
                begin
                    modulus_reg <= cfg_data;
                end
                else if (cfg_index == REG_EXPONENT)
                begin
                    exponent_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        sh_reg   <= sh_next;
        sh2_reg  <= sh2_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        bm_reg   <= bm_next;
        expo_reg <= expo_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        t_reg    <= t_next;
    end

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (plain_value < modulus_reg) || (plain_value == '0))
        else $error("result not reduced");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (modulus_reg >= WIDTH'(2))) |=> busy)
        else $error("accepted transaction did not start");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < den_reg))
        else $error("division remainder out of range");
`endif

endmodule
